// ----- hdl/rpm_tachometer_averager_core_assert.svh -----
// assertion macros for the tachometer averager core
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef RPM_TACHOMETER_AVERAGER_CORE_ASSERT_SVH
`define RPM_TACHOMETER_AVERAGER_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RTA_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RTA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rta_pkg.sv -----
// constants shared by the tachometer averager core
// no dependencies
package rta_pkg;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 27;

    localparam logic [CFG_IW-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PPR      = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DEPTH    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DEAD     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CLOCK_HZ = 3'd4;

    localparam logic [1:0] MODE_USEC = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // field widths
    localparam int IVL_W  = 32;
    localparam int TIME_W = 32;
    localparam int RPM_W  = 16;
    localparam int PPR_W  = 8;
    localparam int DEP_W  = 5;
    localparam int DEAD_W = 16;

    // divider: dividend up to 60 * (2^27 - 1), divisor up to interval * ppr
    localparam int K_W   = 33;
    localparam int DVS_W = IVL_W + PPR_W;
    localparam int Q_W   = RPM_W + 1;

    localparam logic [K_W-1:0]   K_USEC      = 33'd60000000;
    localparam logic [K_W-1:0]   SEC_PER_MIN = 33'd60;
    localparam logic [RPM_W-1:0] RPM_MAX     = 16'hFFFF;

    typedef logic [RPM_W-1:0] t_rpm;

endpackage

// ----- hdl/rpm_tachometer_averager_core.sv -----
// tachometer averager core: interval to rpm conversion and ring average
// depends on rta_pkg and rpm_tachometer_averager_core_assert.svh
// usage:
//   s_axis carries one word per item: tuser is the opcode (0 poll, 1 sample),
//   tdata holds interval (bits 31:0) and now_ms (bits 63:32).
//   m_axis returns one word per item: tdata is rpm, tuser is timed_out.
//   the cfg channel writes registers 0..4 (mode, pulses per rev, depth,
//   dead time, clock rate); it is ready only while the core is idle.
// sequencing:
//   one item at a time; s_axis_tready is low while an item is in work.
//   a sample runs decode, rpm division, ring write, ring sum and mean division, and
//   the next word can be taken once the result is loaded. one restoring divider (one
//   quotient bit per cycle, 17 steps) is used twice, for the rpm conversion and the
//   mean; the ring is summed one entry per cycle through its single read port. a poll
//   or disabled-mode item goes from decode to output, a timed-out poll via a ring write.
// reset clears the registers to their defaults and marks every ring entry
// empty (reads as zero), so no clearing pass is needed.
// the result sits in an output register; a new item is taken while it
// waits, and that item holds in its last step until m_axis_tready frees it.
`include "rpm_tachometer_averager_core_assert.svh"

module rpm_tachometer_averager_core #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rta_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [rta_pkg::CFG_DW-1:0]   i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // interval[31:0], now_ms[63:32]
    input  logic                         s_axis_tuser,   // opcode
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rta_pkg::RPM_W-1:0]    m_axis_tdata,   // rpm[15:0]
    output logic                         m_axis_tuser    // timed_out
);
    import rta_pkg::*;

    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SW    = RPM_W + DW;
    localparam int REM_W = (K_W > SW) ? K_W : SW;
    localparam int DSR_W = DVS_W + RPM_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [4:0] LAST_STEP = 5'(Q_W - 1);

    // configuration
    logic [1:0]        r_mode;
    logic [PPR_W-1:0]  r_ppr;
    logic [DEP_W-1:0]  r_depth;
    logic [DEAD_W-1:0] r_dead;
    logic [CFG_DW-1:0] r_clk_hz;

    // block state
    logic [2:0]           r_state;
    logic [AW-1:0]        r_pos;
    logic [TIME_W-1:0]    r_last;
    t_rpm                 r_cur;
    logic [MAX_DEPTH-1:0] r_vld;
    t_rpm                 r_mem [MAX_DEPTH];

    // latched item
    logic              r_op;
    logic [IVL_W-1:0]  r_ivl;
    logic [TIME_W-1:0] r_now;

    // sequencer and shared divider
    logic              r_conv;
    logic              r_to;
    t_rpm              r_wr_val;
    logic [REM_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [Q_W-1:0]    r_quo;
    logic [4:0]        r_step;
    logic [DW-1:0]     r_cnt;
    logic              r_pend;
    logic [SW-1:0]     r_acc;
    t_rpm              r_rd_data;
    logic              r_rd_vld;

    // output register
    logic              r_m_tvalid;
    t_rpm              r_m_tdata;
    logic              r_m_tuser;

    logic [DW-1:0]     w_depth;
    logic [DW-1:0]     w_pos_ext;
    logic [AW-1:0]     w_wpos;
    logic [DW-1:0]     w_pos_inc;
    logic [AW-1:0]     w_npos;
    logic              w_in_acc;
    logic              w_cfg_wr;
    logic              w_mem_we;
    logic              w_out_load;
    logic              w_enabled;
    logic              w_timeout;
    logic [K_W-1:0]    w_k;
    logic [DVS_W-1:0]  w_prod;
    logic [DSR_W-1:0]  w_rem_ext;
    logic              w_ge;
    logic [DSR_W-1:0]  w_diff;
    logic [REM_W-1:0]  n_rem;
    logic [Q_W-1:0]    n_quo;
    logic [SW-1:0]     n_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign w_out_load    = (r_state == ST_OUT) && (!r_m_tvalid || m_axis_tready);

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // depth clamped to 1..MAX_DEPTH
    always_comb begin
        if (r_depth == '0) begin
            w_depth = DW'(1);
        end else if (32'(r_depth) > 32'(MAX_DEPTH)) begin
            w_depth = DW'(MAX_DEPTH);
        end else begin
            w_depth = DW'(r_depth);
        end
    end

    // ring write position and its successor
    assign w_pos_ext = DW'(r_pos);
    assign w_wpos    = (w_pos_ext >= w_depth) ? '0 : r_pos;
    assign w_pos_inc = DW'(w_wpos) + DW'(1);
    assign w_npos    = (w_pos_inc >= w_depth) ? '0 : w_pos_inc[AW-1:0];
    assign w_mem_we  = (r_state == ST_WR);

    assign w_enabled = (r_mode == MODE_USEC) || (r_mode == MODE_TICK);
    assign w_timeout = (r_now - r_last) > TIME_W'(r_dead);

    assign w_k    = (r_mode == MODE_USEC) ? K_USEC : K_W'(r_clk_hz) * SEC_PER_MIN;
    assign w_prod = DVS_W'(r_ivl) * DVS_W'(r_ppr);

    // one restoring step; a zero divisor sets the top quotient bit and saturates
    assign w_rem_ext = DSR_W'(r_rem);
    assign w_ge      = (w_rem_ext >= r_dsr);
    assign w_diff    = w_rem_ext - r_dsr;
    assign n_rem     = w_ge ? w_diff[REM_W-1:0] : r_rem;
    assign n_quo     = {r_quo[Q_W-2:0], w_ge};

    assign n_acc = r_pend ? (r_acc + SW'(r_rd_vld ? r_rd_data : '0)) : r_acc;

    // ring storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wpos] <= r_wr_val;
        end
        r_rd_data <= r_mem[r_cnt[AW-1:0]];
        r_rd_vld  <= r_vld[r_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 2'd0;
            r_ppr      <= PPR_W'(1);
            r_depth    <= DEP_W'(4);
            r_dead     <= DEAD_W'(500);
            r_clk_hz   <= CFG_DW'(16000000);
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_last     <= '0;
            r_cur      <= '0;
            r_vld      <= '0;
            r_m_tvalid <= 1'b0;
            r_step     <= '0;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            if (w_cfg_wr) begin
                case (i_cfg_index)
                    REG_MODE: begin
                        r_mode <= i_cfg_data[1:0];
                        r_cur  <= '0;
                    end
                    REG_PPR: begin
                        r_ppr <= i_cfg_data[PPR_W-1:0];
                    end
                    REG_DEPTH: begin
                        r_depth <= i_cfg_data[DEP_W-1:0];
                        r_vld   <= '0;
                        r_pos   <= '0;
                    end
                    REG_DEAD: begin
                        r_dead <= i_cfg_data[DEAD_W-1:0];
                    end
                    REG_CLOCK_HZ: begin
                        r_clk_hz <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= s_axis_tuser;
                        r_ivl   <= s_axis_tdata[IVL_W-1:0];
                        r_now   <= s_axis_tdata[63:IVL_W];
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    if (!w_enabled) begin
                        r_to    <= 1'b0;
                        r_cur   <= '0;
                        r_state <= ST_OUT;
                    end else if (r_op == OP_SAMPLE) begin
                        r_to    <= 1'b0;
                        r_last  <= r_now;
                        r_conv  <= 1'b1;
                        r_rem   <= REM_W'(w_k);
                        r_dsr   <= {w_prod, RPM_W'(0)};
                        r_quo   <= '0;
                        r_step  <= LAST_STEP;
                        r_state <= ST_DIV;
                    end else if (w_timeout) begin
                        r_last   <= r_now;
                        r_conv   <= 1'b0;
                        r_wr_val <= '0;
                        r_cur    <= '0;
                        r_to     <= 1'b1;
                        r_state  <= ST_WR;
                    end else begin
                        r_to    <= 1'b0;
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_dsr  <= r_dsr >> 1;
                    r_step <= r_step - 5'd1;
                    if (r_step == '0) begin
                        if (r_conv) begin
                            r_wr_val <= n_quo[Q_W-1] ? RPM_MAX : n_quo[RPM_W-1:0];
                            r_state  <= ST_WR;
                        end else begin
                            r_cur   <= n_quo[RPM_W-1:0];
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_WR: begin
                    r_vld[w_wpos] <= 1'b1;
                    r_pos         <= w_npos;
                    r_cnt         <= '0;
                    r_pend        <= 1'b0;
                    r_acc         <= '0;
                    r_state       <= r_conv ? ST_SUM : ST_OUT;
                end
                ST_SUM: begin
                    r_acc <= n_acc;
                    if (r_cnt < w_depth) begin
                        r_cnt  <= r_cnt + DW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // last read lands this cycle; hand the sum to the divider
                    if (r_cnt == w_depth && r_pend) begin
                        r_conv  <= 1'b0;
                        r_rem   <= REM_W'(n_acc);
                        r_dsr   <= DSR_W'(w_depth) << RPM_W;
                        r_quo   <= '0;
                        r_step  <= LAST_STEP;
                        r_state <= ST_DIV;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_m_tdata  <= r_cur;
                        r_m_tuser  <= r_to;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `RTA_ASSERT_NEXT(a_accept_decodes, w_in_acc, r_state == ST_DEC, "accepted word not decoded")
    `RTA_ASSERT_HOLDS(a_pos_in_ring, (r_state != ST_IDLE) || (w_pos_ext < w_depth), "ring position beyond depth")
    `RTA_ASSERT_IMPL(a_sum_bound, r_state == ST_SUM, r_cnt <= w_depth, "ring sum ran past depth")
    `RTA_ASSERT_IMPL(a_timeout_zero, r_m_tvalid && r_m_tuser, r_m_tdata == '0, "timeout with nonzero rpm")

endmodule
